// ----- sv/frst_pkg.sv -----
// shared constants and controller/datapath interface types for the slot table
package frst_pkg;

  localparam int NUM_CLIENTS      = 16;
  localparam int SLOTS_PER_CLIENT = 32;

  localparam int CLIENT_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int SLOT_W    = (SLOTS_PER_CLIENT > 1) ? $clog2(SLOTS_PER_CLIENT) : 1;
  localparam int ENT_DEPTH = NUM_CLIENTS << SLOT_W;

  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int COUNT_W = 10;
  localparam int ENT_W   = ID_W + TIME_W;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_NONE   = 2'd3
  } frst_command_t;

  typedef struct packed {
    logic accept;
    logic tick;
    logic row_rd;
    logic scan;
    logic update;
    logic load_out;
  } frst_cmd_t;

  typedef struct packed {
    logic lookup_ok;
    logic is_tick;
    logic is_sweep;
    logic idx_last;
    logic row_last;
  } frst_status_t;

endpackage

// ----- sv/frst_ctrl.sv -----
// controller state machine sequencing lookups, ticks and sweeps
module frst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  frst_pkg::frst_status_t status,
  output frst_pkg::frst_cmd_t    cmd
);
  import frst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_ROW,
    S_SCAN,
    S_DRAIN,
    S_UPD,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid && in_ready;
    cmd.tick     = (state == S_DEC) && status.is_tick;
    cmd.row_rd   = (state == S_ROW);
    cmd.scan     = (state == S_SCAN);
    cmd.update   = (state == S_UPD);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result loads as the old one leaves, otherwise hold until taken
      out_valid <= cmd.load_out || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          in_ready <= !(in_valid && in_ready);
          if (in_valid && in_ready) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (status.lookup_ok || status.is_sweep) begin
            state <= S_ROW;
          end else begin
            state <= S_FIN;
          end
        end
        S_ROW: state <= S_SCAN;
        S_SCAN: begin
          if (status.idx_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_UPD;
        S_UPD: begin
          if (status.is_sweep && !status.row_last) begin
            state <= S_ROW;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            in_ready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/frst_datapath.sv -----
// slot memories, scan pipeline, time counter and result registers
module frst_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    command,
  input  logic [3:0]                    client,
  input  logic [frst_pkg::ID_W-1:0]     frag_id,
  input  logic                          cfg_wr_en,
  input  logic [frst_pkg::TMO_W-1:0]    cfg_wr_data,
  input  frst_pkg::frst_cmd_t           cmd,
  output frst_pkg::frst_status_t        status,
  output logic [4:0]                    slot,
  output logic                          found_existing,
  output logic                          newly_created,
  output logic                          table_full,
  output logic [frst_pkg::COUNT_W-1:0]  expired_count
);
  import frst_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam logic [SLOT_W-1:0]  IDX_LAST  = SLOT_W'(SLOTS_PER_CLIENT - 1);
  localparam logic [CLIENT_W-1:0] ROW_LAST = CLIENT_W'(NUM_CLIENTS - 1);

  // latched transaction
  logic [1:0]          cmd_r;
  logic [3:0]          client_r;
  logic [ID_W-1:0]     id_r;

  logic [TIME_W-1:0]   now;
  logic [TMO_W-1:0]    timeout;

  logic [CLIENT_W-1:0] row;
  logic [SLOT_W-1:0]   idx;
  logic [SLOT_W-1:0]   idx_d;
  logic                ent_vld_d;

  logic [SLOTS_PER_CLIENT-1:0] act_mem [NUM_CLIENTS];
  logic [ENT_W-1:0]            ent_mem [ENT_DEPTH];
  logic [NUM_CLIENTS-1:0]      row_valid;

  logic [SLOTS_PER_CLIENT-1:0] row_q;
  logic                        row_vld_q;
  logic [ENT_W-1:0]            ent_q;

  logic                        found;
  logic [SLOT_W-1:0]           hit_idx;
  logic                        free_found;
  logic [SLOT_W-1:0]           free_idx;
  logic [SLOTS_PER_CLIENT-1:0] expmask;
  logic [COUNT_W-1:0]          count;

  logic [SLOTS_PER_CLIENT-1:0] act;
  logic                        cur_act;
  logic [TIME_W-1:0]           age;
  logic                        hit;
  logic                        expired;
  logic                        is_lookup;
  logic                        lookup_ok;
  logic                        is_sweep;
  logic                        ent_we;
  logic [SLOT_W-1:0]           ent_widx;

  logic [4:0]                  res_slot;
  logic                        res_found;
  logic                        res_new;
  logic                        res_full;
  logic [COUNT_W-1:0]          res_count;

  assign act       = row_vld_q ? row_q : '0;
  assign cur_act   = act[idx_d];
  assign age       = now - ent_q[TIME_W-1:0];
  assign hit       = cur_act && (ent_q[ENT_W-1:TIME_W] == id_r);
  assign expired   = cur_act && (age > TIME_W'(timeout));

  assign is_lookup = (cmd_r == CMD_LOOKUP);
  assign lookup_ok = is_lookup && (32'(client_r) < 32'(NUM_CLIENTS));
  assign is_sweep  = (cmd_r == CMD_SWEEP);

  assign status.lookup_ok = lookup_ok;
  assign status.is_tick   = (cmd_r == CMD_TICK);
  assign status.is_sweep  = is_sweep;
  assign status.idx_last  = (idx == IDX_LAST);
  assign status.row_last  = (row == ROW_LAST);

  assign ent_we   = cmd.update && lookup_ok && (found || free_found);
  assign ent_widx = found ? hit_idx : free_idx;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now       <= '0;
      timeout   <= TMO_W'(30);
      row_valid <= '0;
      ent_vld_d <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (cmd.tick) begin
        now <= now + 1'b1;
      end
      if (cmd.update && (is_sweep || (lookup_ok && !found && free_found))) begin
        row_valid[row] <= 1'b1;
      end
      ent_vld_d <= cmd.scan;
    end
  end

  // transaction latch, counters and scan results
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= command;
      client_r <= client;
      id_r     <= frag_id;
      count    <= '0;
      row      <= (command == CMD_LOOKUP) ? CLIENT_W'(client) : '0;
    end else if (cmd.update && is_sweep && !status.row_last) begin
      row <= row + 1'b1;
    end
    if (cmd.row_rd) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      expmask    <= '0;
    end else if (cmd.scan) begin
      idx <= idx + 1'b1;
    end
    idx_d <= idx;
    if (ent_vld_d) begin
      if (hit && !found) begin
        found   <= 1'b1;
        hit_idx <= idx_d;
      end
      if (!cur_act && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx_d;
      end
      if (is_sweep && expired) begin
        expmask[idx_d] <= 1'b1;
        if (count != COUNT_SAT) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // active-bit row memory
  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      row_q     <= act_mem[row];
      row_vld_q <= row_valid[row];
    end
    if (cmd.update && is_sweep) begin
      act_mem[row] <= act & ~expmask;
    end else if (cmd.update && lookup_ok && !found && free_found) begin
      act_mem[row] <= act | (SLOTS_PER_CLIENT'(1) << free_idx);
    end
  end

  // packet id and timestamp memory
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      ent_q <= ent_mem[{row, idx}];
    end
    if (ent_we) begin
      ent_mem[{row, ent_widx}] <= {id_r, now};
    end
  end

  always_comb begin
    res_found = lookup_ok && found;
    res_new   = lookup_ok && !found && free_found;
    res_full  = lookup_ok && !found && !free_found;
    res_slot  = res_found ? 5'(hit_idx) : (res_new ? 5'(free_idx) : 5'd0);
    res_count = is_sweep ? count : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slot           <= res_slot;
      found_existing <= res_found;
      newly_created  <= res_new;
      table_full     <= res_full;
      expired_count  <= res_count;
    end
  end

endmodule

// ----- sv/fragment_reassembly_slot_table_top.sv -----
// top level of the fragment reassembly slot table with sweep-based timeout
// Per-client table of reassembly slots. A lookup transaction (command 0) searches the client's
// slots for an active entry holding frag_id, refreshing its timestamp on a hit, otherwise
// claiming the lowest free slot, otherwise reporting table_full. Command 1 advances the
// internal 32-bit seconds counter by one tick; command 2 sweeps every slot of every client and
// frees those whose age (counter minus timestamp, modulo 2^32) is above timeout_seconds,
// returning how many were freed in expired_count. Command 3 and lookups for a client beyond
// the table return all-zero results. Each input transaction yields exactly one result
// transaction. The block works on one transaction at a time; the slot ids and timestamps sit
// in a single-port memory read one entry per cycle, so a lookup scans every slot of its client
// and a sweep scans every slot of every client, row by row. The output register lets the next
// transaction be taken and worked on while a result is still waiting for out_ready. No clearing
// pass is needed after reset: each client's row of active bits carries its own valid flop.
// timeout_seconds resets to 30; the user is to write it through cfg_wr_en / cfg_wr_data only
// while the block is idle, which the block itself does not enforce.
module fragment_reassembly_slot_table_top (
  input  logic                          clk,
  input  logic                          rst,
  // input transaction channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [3:0]                    client,
  input  logic [frst_pkg::ID_W-1:0]     frag_id,
  // result transaction channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    slot,
  output logic                          found_existing,
  output logic                          newly_created,
  output logic                          table_full,
  output logic [frst_pkg::COUNT_W-1:0]  expired_count,
  // timeout register write
  input  logic                          cfg_wr_en,
  input  logic [frst_pkg::TMO_W-1:0]    cfg_wr_data
);
  import frst_pkg::*;

  frst_cmd_t    cmd;
  frst_status_t status;

  // sequencing: accept, decode, row read, entry scan, drain, write back, result load
  frst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // memories, time counter, compare logic and result registers
  frst_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .command        (command),
    .client         (client),
    .frag_id        (frag_id),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .status         (status),
    .slot           (slot),
    .found_existing (found_existing),
    .newly_created  (newly_created),
    .table_full     (table_full),
    .expired_count  (expired_count)
  );

`ifndef NO_ASSERTIONS
  // a result flags at most one lookup outcome of hit, claim or drop, never more
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({found_existing, newly_created, table_full}) <= 1)
    else $error("more than one lookup outcome flagged");

  // a sweep count never comes with a lookup outcome
  a_count_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && expired_count != '0) |->
      (!found_existing && !newly_created && !table_full && slot == 5'd0))
    else $error("sweep count mixed with lookup result");

  // dropped lookups report slot zero
  a_drop_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (slot == 5'd0))
    else $error("dropped lookup carries a slot index");

  // the controller never loads a result over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");
`endif

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the fragment reassembly slot table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import frst_pkg::*;

  localparam int TOTAL_SLOTS   = NUM_CLIENTS * SLOTS_PER_CLIENT;
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int TIMEOUT_RESET = 30;
  // longer than a sweep, the slowest transaction
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_CYCLES   = 3000;
  // no handshake at all for this long means the block is stuck
  localparam int IDLE_LIMIT    = 20000;
  localparam int POOL_SIZE     = 8;

  // one result transaction, field for field
  typedef struct packed {
    logic [4:0]         slot;
    logic               found_existing;
    logic               newly_created;
    logic               table_full;
    logic [COUNT_W-1:0] expired_count;
  } slot_outcome_t;

  // mirror of the slot table plus the queue of outcomes still to come back
  class slot_table_scoreboard;
    bit                active    [TOTAL_SLOTS];
    logic [ID_W-1:0]   held_id   [TOTAL_SLOTS];
    logic [TIME_W-1:0] last_seen [TOTAL_SLOTS];
    logic [TIME_W-1:0] seconds;
    logic [TMO_W-1:0]  timeout;
    slot_outcome_t     expected_outcomes[$];
    int unsigned       mismatches;

    function new();
      foreach (active[k]) begin
        active[k]    = 1'b0;
        held_id[k]   = '0;
        last_seen[k] = '0;
      end
      seconds    = '0;
      timeout    = TMO_W'(TIMEOUT_RESET);
      mismatches = 0;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // apply one accepted transaction to the mirror and queue its outcome
    function void note_command(frst_command_t cmd, logic [3:0] cl, logic [ID_W-1:0] id);
      slot_outcome_t     r;
      int                base;
      int                hit;
      int                vacant;
      int unsigned       freed;
      logic [TIME_W-1:0] age;
      r = '0;
      case (cmd)
        CMD_LOOKUP: begin
          if (int'(cl) < NUM_CLIENTS) begin
            base   = int'(cl) * SLOTS_PER_CLIENT;
            hit    = -1;
            vacant = -1;
            for (int i = 0; i < SLOTS_PER_CLIENT; i++) begin
              if (hit < 0 && active[base+i] && held_id[base+i] == id)
                hit = i;
              if (vacant < 0 && !active[base+i])
                vacant = i;
            end
            if (hit >= 0) begin
              last_seen[base+hit] = seconds;
              r.slot              = 5'(hit);
              r.found_existing    = 1'b1;
            end else if (vacant >= 0) begin
              active[base+vacant]    = 1'b1;
              held_id[base+vacant]   = id;
              last_seen[base+vacant] = seconds;
              r.slot                 = 5'(vacant);
              r.newly_created        = 1'b1;
            end else begin
              r.table_full = 1'b1;
            end
          end
        end
        CMD_TICK: begin
          seconds = seconds + 1'b1;
        end
        CMD_SWEEP: begin
          freed = 0;
          for (int k = 0; k < TOTAL_SLOTS; k++) begin
            age = seconds - last_seen[k];
            if (active[k] && age > timeout) begin
              active[k]    = 1'b0;
              held_id[k]   = '0;
              last_seen[k] = '0;
              if (freed < COUNT_MAX)
                freed++;
            end
          end
          r.expired_count = COUNT_W'(freed);
        end
        default: ;
      endcase
      expected_outcomes.push_back(r);
    endfunction

    function void check_outcome(slot_outcome_t got);
      slot_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: %0t unexpected slot=%0d found=%0b new=%0b full=%0b expired=%0d",
                   $time, got.slot, got.found_existing, got.newly_created, got.table_full,
                   got.expired_count);
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.slot !== want.slot || got.found_existing !== want.found_existing ||
          got.newly_created !== want.newly_created || got.table_full !== want.table_full ||
          got.expired_count !== want.expired_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: %0t expected slot=%0d found=%0b new=%0b full=%0b expired=%0d",
                   $time, want.slot, want.found_existing, want.newly_created, want.table_full,
                   want.expired_count);
          $display("ERROR: %0t actual   slot=%0d found=%0b new=%0b full=%0b expired=%0d",
                   $time, got.slot, got.found_existing, got.newly_created, got.table_full,
                   got.expired_count);
        end
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [1:0]         command     = '0;
  logic [3:0]         client      = '0;
  logic [ID_W-1:0]    frag_id     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [4:0]         slot;
  logic               found_existing;
  logic               newly_created;
  logic               table_full;
  logic [COUNT_W-1:0] expired_count;
  logic               cfg_wr_en   = 1'b0;
  logic [TMO_W-1:0]   cfg_wr_data = '0;

  // set by the stimulus to ask the receiver for one long hold-off
  bit hold_req = 1'b0;

  slot_table_scoreboard sb;

  fragment_reassembly_slot_table_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .client         (client),
    .frag_id        (frag_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .slot           (slot),
    .found_existing (found_existing),
    .newly_created  (newly_created),
    .table_full     (table_full),
    .expired_count  (expired_count),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // present one transaction and hold it until the block takes it;
  // valid is left high so a following transaction can go back to back
  task automatic offer(frst_command_t cmd, logic [3:0] cl, logic [ID_W-1:0] id);
    in_valid  <= 1'b1;
    command   <= cmd;
    client    <= cl;
    frag_id   <= id;
    // in_ready read at the edge is its value just before the edge
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, cl, id);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // the timeout register only changes while the block sits idle
  task automatic set_timeout(logic [TMO_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.timeout = value;
  endtask

  // random traffic: command mix in percent, optional focus on two clients so
  // their tables fill, ids drawn partly from a small pool so lookups hit
  task automatic random_phase(int count, int lookup_pct, int tick_pct, int sweep_pct,
                              bit focused, int gap_pct);
    logic [ID_W-1:0] pool [POOL_SIZE];
    int              done;
    int              burst;
    int              roll;
    frst_command_t   cmd;
    logic [3:0]      cl;
    logic [ID_W-1:0] id;
    foreach (pool[i])
      pool[i] = ID_W'($urandom);
    done  = 0;
    burst = $urandom_range(1, 20);
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < lookup_pct)
        cmd = CMD_LOOKUP;
      else if (roll < lookup_pct + tick_pct)
        cmd = CMD_TICK;
      else if (roll < lookup_pct + tick_pct + sweep_pct)
        cmd = CMD_SWEEP;
      else
        cmd = CMD_NONE;
      if (focused && $urandom_range(99) < 80)
        cl = 4'($urandom_range(1));
      else
        cl = 4'($urandom);
      if ($urandom_range(99) < (focused ? 20 : 60))
        id = pool[$urandom_range(POOL_SIZE - 1)];
      else
        id = ID_W'($urandom);
      offer(cmd, cl, id);
      done++;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(99) < gap_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 60)) @(posedge clk);
        end
      end
    end
  endtask

  // main stimulus
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset timeout: field extremes and every command
    offer(CMD_LOOKUP, 4'd0,  16'h0000);   // first claim in client 0
    offer(CMD_LOOKUP, 4'd15, 16'hFFFF);   // first claim in the last client
    offer(CMD_LOOKUP, 4'd0,  16'hFFFF);   // next free slot
    offer(CMD_LOOKUP, 4'd0,  16'h0000);   // hit on an active id
    offer(CMD_LOOKUP, 4'd15, 16'h0000);   // same id, other client
    offer(CMD_NONE,   4'd15, 16'hFFFF);   // unused command, all-zero result
    offer(CMD_NONE,   4'd0,  16'h0000);
    offer(CMD_TICK,   4'd0,  16'h0000);
    offer(CMD_SWEEP,  4'd0,  16'h0000);   // nothing old enough yet
    offer(CMD_TICK,   4'd15, 16'hFFFF);   // payload ignored on tick
    offer(CMD_SWEEP,  4'd15, 16'hFFFF);
    offer(CMD_LOOKUP, 4'd15, 16'hFFFF);   // refresh
    offer(CMD_LOOKUP, 4'd7,  16'hA5A5);
    offer(CMD_LOOKUP, 4'd8,  16'h5A5A);

    // reset timeout of 30 with enough ticks for slots to age out
    random_phase(200, 55, 25, 8, 1'b0, 60);

    // zero timeout: any slot one tick old expires
    set_timeout(16'd0);
    offer(CMD_TICK,   4'd3,  16'h1234);
    offer(CMD_SWEEP,  4'd3,  16'h1234);   // frees everything active
    offer(CMD_LOOKUP, 4'd0,  16'hFFFF);   // table empty again, slot 0
    random_phase(100, 55, 25, 8, 1'b0, 40);

    // largest timeout and traffic on two clients: tables fill and drop
    set_timeout(16'hFFFF);
    random_phase(150, 88, 5, 4, 1'b1, 30);

    // short timeout, sender never idles
    set_timeout(16'($urandom_range(1, 12)));
    random_phase(200, 55, 30, 8, 1'b0, 0);

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    repeat (10)
      offer(CMD_LOOKUP, 4'($urandom), ID_W'($urandom));

    set_timeout(16'($urandom));
    random_phase(100, 60, 25, 8, 1'b0, 50);

    set_timeout(16'd1);
    random_phase(150, 55, 30, 8, 1'b0, 80);

    // wait for the last results, then let the block settle
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall pattern whose density is itself redrawn at random,
  // plus one long hold-off on request
  initial begin
    int ready_pct;
    int left;
    bit hold_done;
    ready_pct = 100;
    left      = 0;
    hold_done = 1'b0;
    while (rst)
      @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          case ($urandom_range(3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 35;
            default: ready_pct = 10;
          endcase
          left = $urandom_range(40, 400);
        end
        left--;
        out_ready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  // result monitor: every accepted result transaction is checked in order
  always @(posedge clk) begin : result_monitor
    slot_outcome_t got;
    if (!rst && out_valid && out_ready) begin
      got.slot           = slot;
      got.found_existing = found_existing;
      got.newly_created  = newly_created;
      got.table_full     = table_full;
      got.expired_count  = expired_count;
      sb.check_outcome(got);
    end
  end

  // watchdog: too long without any transaction on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
